/* rtl/cvp_pkg.sv */
// Package for the coin validator pulse device: types, codes and constants.
package cvp_pkg;

    // Number of denominations covered by the mask, and the largest coin value
    localparam int DENOM_COUNT = 48;
    localparam int MAX_PULSES  = 48;
    localparam logic [9:0] MAX_CENTS = 10'(5 * DENOM_COUNT);

    // Width or gap of zero falls back to this
    localparam logic [15:0] DEFAULT_TICKS = 16'd350;

    // Reset values of the configuration registers
    localparam logic [1:0]  MODE_RESET  = 2'd1;
    localparam logic [47:0] MASK_RESET  = 48'd524307;
    localparam logic [15:0] WIDTH_RESET = 16'd4200;
    localparam logic [15:0] GAP_RESET   = 16'd4200;

    // Register indexes (byte address is 8 * index)
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_MASK  = 2'd1;
    localparam logic [1:0] REG_WIDTH = 2'd2;
    localparam logic [1:0] REG_GAP   = 2'd3;

    // Validator modes that take coins
    localparam logic [1:0] MODE_PULSE = 2'd1;
    localparam logic [1:0] MODE_UART  = 2'd2;

    // Control byte bits
    localparam int CTL_DISABLE     = 0;
    localparam int CTL_CLR_JAM     = 1;
    localparam int CTL_CLR_REJECT  = 2;

    typedef enum logic [2:0] {
        REQ_TICK,
        REQ_CTRL,
        REQ_INSERT,
        REQ_JAM,
        REQ_REJECT,
        REQ_READ,
        REQ_CMD,
        REQ_TIMEOUT
    } req_kind_t;

    typedef enum logic [3:0] {
        CMD_WAKE,
        CMD_SLEEP,
        CMD_CHECKSUM,
        CMD_LEARN,
        CMD_ENABLE,
        CMD_COLLECT,
        CMD_REFUND,
        CMD_POLL,
        CMD_RESET_FAULT
    } cmd_code_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] control_data;
        logic [9:0] coin_cents;
        logic [3:0] command;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  status;
        logic        accepted;
        logic        frame_fault;
        logic        frame_sensor;
        logic [15:0] timeout_count;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  validator_mode;
        logic [47:0] denom_mask;
        logic [15:0] pulse_width_ticks;
        logic [15:0] gap_ticks;
    } cfg_t;

endpackage

/* rtl/cvp_regs.sv */
// Configuration register file behind the APB-style port.
module cvp_regs
    import cvp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [1:0]  mode_reg;
    logic [47:0] mask_reg;
    logic [15:0] width_reg;
    logic [15:0] gap_reg;
    logic        wr_en;
    logic [1:0]  index;

    assign index  = paddr[4:3];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;

    // Register writes in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_RESET;
            mask_reg  <= MASK_RESET;
            width_reg <= WIDTH_RESET;
            gap_reg   <= GAP_RESET;
        end
        else if (wr_en)
        begin
            case (index)
                REG_MODE:  mode_reg  <= pwdata[1:0];
                REG_MASK:  mask_reg  <= pwdata[47:0];
                REG_WIDTH: width_reg <= pwdata[15:0];
                REG_GAP:   gap_reg   <= pwdata[15:0];
                default:   ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (index)
            REG_MODE:  prdata = {62'd0, mode_reg};
            REG_MASK:  prdata = {16'd0, mask_reg};
            REG_WIDTH: prdata = {48'd0, width_reg};
            REG_GAP:   prdata = {48'd0, gap_reg};
            default:   prdata = 64'd0;
        endcase
    end

    assign cfg = '{validator_mode:    mode_reg,
                   denom_mask:        mask_reg,
                   pulse_width_ticks: width_reg,
                   gap_ticks:         gap_reg};

endmodule

/* rtl/cvp_core.sv */
// Device state and the single-pass update for one request.
module cvp_core
    import cvp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      fire,
    input  in_item_t  item,
    output out_item_t result
);

    logic        disabled_reg, disabled_next;
    logic        jam_reg, jam_next;
    logic        reject_reg, reject_next;
    logic        emitting_reg, emitting_next;
    logic [7:0]  escrow_reg, escrow_next;
    logic [5:0]  target_reg, target_next;
    logic [5:0]  index_reg, index_next;
    logic [16:0] phase_reg, phase_next;
    logic [15:0] timeouts_reg, timeouts_next;

    logic [15:0] w_eff, g_eff;
    logic [16:0] w_ext, wg_sum, phase_inc;
    logic [7:0]  cents_lo;
    logic [15:0] prod;
    logic [5:0]  n_pulses, n_m1;
    logic [7:0]  n_times5;
    logic        insert_ok;
    logic        ok, is_cmd, ffault, fsensor, line_high;
    req_kind_t   kind;

    // Effective timing with zero mapped to the default
    assign w_eff     = (cfg.pulse_width_ticks == 16'd0) ? DEFAULT_TICKS : cfg.pulse_width_ticks;
    assign g_eff     = (cfg.gap_ticks == 16'd0) ? DEFAULT_TICKS : cfg.gap_ticks;
    assign w_ext     = {1'b0, w_eff};
    assign wg_sum    = {1'b0, w_eff} + {1'b0, g_eff};
    assign phase_inc = phase_reg + 17'd1;

    // Coin check: divide the low 8 bits by 5 through the reciprocal 205/1024 (exact for these values)
    assign cents_lo = item.coin_cents[7:0];
    assign prod     = {8'd0, cents_lo} * 16'd205;
    assign n_pulses = prod[15:10];
    assign n_times5 = {n_pulses, 2'b00} + {2'b00, n_pulses};
    assign n_m1     = n_pulses - 6'd1;
    assign insert_ok = !disabled_reg && !jam_reg
                    && (cfg.validator_mode == MODE_PULSE || cfg.validator_mode == MODE_UART)
                    && (item.coin_cents != 10'd0)
                    && (item.coin_cents <= MAX_CENTS)
                    && (n_times5 == cents_lo)
                    && ({1'b0, n_pulses} <= 7'(MAX_PULSES))
                    && cfg.denom_mask[n_m1];

    assign kind = req_kind_t'(item.req_type);

    // Next state and result fields
    always_comb
    begin
        disabled_next = disabled_reg;
        jam_next      = jam_reg;
        reject_next   = reject_reg;
        emitting_next = emitting_reg;
        escrow_next   = escrow_reg;
        target_next   = target_reg;
        index_next    = index_reg;
        phase_next    = phase_reg;
        timeouts_next = timeouts_reg;
        ok            = 1'b1;
        is_cmd        = 1'b0;
        ffault        = jam_reg;
        fsensor       = (escrow_reg != 8'd0);

        case (kind)
            REQ_TICK:
            begin
                if (emitting_reg)
                begin
                    if (target_reg == 6'd0)
                    begin
                        emitting_next = 1'b0;
                    end
                    else
                    begin
                        phase_next = phase_inc;
                        if (({1'b0, index_reg} + 7'd1 >= {1'b0, target_reg})
                            && (phase_inc >= w_ext))
                        begin
                            emitting_next = 1'b0;
                            index_next    = 6'd0;
                            phase_next    = 17'd0;
                        end
                        else if (phase_inc >= wg_sum)
                        begin
                            index_next = index_reg + 6'd1;
                            phase_next = 17'd0;
                        end
                    end
                end
            end
            REQ_CTRL:
            begin
                disabled_next = item.control_data[CTL_DISABLE];
                if (item.control_data[CTL_CLR_JAM])
                begin
                    jam_next    = 1'b0;
                    reject_next = 1'b0;
                end
                if (item.control_data[CTL_CLR_REJECT])
                begin
                    reject_next = 1'b0;
                end
            end
            REQ_INSERT:
            begin
                ok = insert_ok;
                if (insert_ok)
                begin
                    // value is at most 240 here, so no saturation
                    escrow_next   = cents_lo;
                    target_next   = n_pulses;
                    index_next    = 6'd0;
                    phase_next    = 17'd0;
                    emitting_next = 1'b1;
                    reject_next   = 1'b0;
                end
            end
            REQ_JAM, REQ_REJECT:
            begin
                if (kind == REQ_JAM)
                begin
                    jam_next = 1'b1;
                end
                else
                begin
                    reject_next = 1'b1;
                end
                emitting_next = 1'b0;
                escrow_next   = 8'd0;
                target_next   = 6'd0;
                index_next    = 6'd0;
                phase_next    = 17'd0;
            end
            REQ_READ:
            begin
            end
            REQ_CMD:
            begin
                is_cmd = 1'b1;
                case (item.command)
                    CMD_WAKE, CMD_ENABLE:
                        disabled_next = 1'b0;
                    CMD_SLEEP:
                        disabled_next = 1'b1;
                    CMD_CHECKSUM, CMD_POLL:
                    begin
                    end
                    CMD_LEARN:
                    begin
                        jam_next    = 1'b0;
                        reject_next = 1'b0;
                        escrow_next = 8'd0;
                        ffault      = 1'b0;
                        fsensor     = 1'b0;
                    end
                    CMD_COLLECT, CMD_REFUND:
                    begin
                        if (escrow_reg == 8'd0)
                        begin
                            ok = 1'b0;
                        end
                        else
                        begin
                            escrow_next = 8'd0;
                            fsensor     = 1'b0;
                            if (item.command == CMD_REFUND)
                            begin
                                reject_next = 1'b1;
                            end
                        end
                    end
                    CMD_RESET_FAULT:
                    begin
                        jam_next    = 1'b0;
                        reject_next = 1'b0;
                        ffault      = 1'b0;
                    end
                    default:
                        ok = 1'b0;
                endcase
            end
            REQ_TIMEOUT:
            begin
                timeouts_next = timeouts_reg + 16'd1;
                jam_next      = 1'b1;
            end
            default:
            begin
            end
        endcase

        // Non-command items report the latches after the update
        if (!is_cmd)
        begin
            ffault  = jam_next;
            fsensor = (escrow_next != 8'd0);
        end
    end

    assign line_high = emitting_next && !jam_next && (target_next != 6'd0)
                    && (phase_next < w_ext);

    assign result = '{status:        {disabled_next, reject_next, jam_next,
                                      !disabled_next && !jam_next, line_high},
                      accepted:      ok,
                      frame_fault:   ffault,
                      frame_sensor:  fsensor,
                      timeout_count: timeouts_next};

    // State update on each processed request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disabled_reg <= 1'b0;
            jam_reg      <= 1'b0;
            reject_reg   <= 1'b0;
            emitting_reg <= 1'b0;
            escrow_reg   <= 8'd0;
            target_reg   <= 6'd0;
            index_reg    <= 6'd0;
            phase_reg    <= 17'd0;
            timeouts_reg <= 16'd0;
        end
        else if (fire)
        begin
            disabled_reg <= disabled_next;
            jam_reg      <= jam_next;
            reject_reg   <= reject_next;
            emitting_reg <= emitting_next;
            escrow_reg   <= escrow_next;
            target_reg   <= target_next;
            index_reg    <= index_next;
            phase_reg    <= phase_next;
            timeouts_reg <= timeouts_next;
        end
    end

endmodule

/* rtl/coin_validator_pulse_device.sv */
// Path: the request is held in the input register, then its result in the result register;
// a stall on rsp_ready holds the item in the input register.
// Throughput: one request per cycle; the core updates all state in a single pass.
// The response register frees in the cycle it is taken, so full rate holds under no stall.
// Reset (rst_n, async, active low) clears device state and pipeline valids;
// configuration returns to mode 1, mask 0x80013, width and gap 4200.
module coin_validator_pulse_device
    import cvp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  in_item_t    req,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output out_item_t   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    cfg_t      cfg;
    logic      stage_valid_reg;
    in_item_t  stage_reg;
    logic      rsp_valid_reg;
    out_item_t rsp_reg;
    out_item_t result;
    logic      out_free;
    logic      fire;

    cvp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cvp_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .fire   (fire),
        .item   (stage_reg),
        .result (result)
    );

    // Flow control between the stages
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign fire      = stage_valid_reg && out_free;
    assign req_ready = !stage_valid_reg || fire;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                stage_valid_reg <= req_valid;
            end
            if (out_free)
            begin
                rsp_valid_reg <= fire;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            stage_reg <= req;
        end
        if (fire)
        begin
            rsp_reg <= result;
        end
    end

endmodule
